// File: src/mrfa_pkg.sv
// ----------------------------------------------------------------------------
// mrfa_pkg: shared types and constants for the mirror reflection block
// Holds the CORDIC vector type, pipeline control type, register indexes,
// angle constants and the arctangent table.
// ----------------------------------------------------------------------------
package mrfa_pkg;

    localparam int CW    = 34;   // CORDIC datapath width, Q2.30 plus headroom
    localparam int STEPS = 30;   // number of CORDIC cells
    localparam int NREG  = 8;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [27:0]          RAD_PER_DEG = 28'd74961321;  // pi/180, Q0.32

    // Degree constants in Q16.16
    localparam logic [24:0]        DEG_HALF    = 25'd11796480;
    localparam logic signed [25:0] DEG_FULL    = 26'sd23592960;
    localparam logic signed [25:0] DEG_QUARTER = 26'sd5898240;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_ANGLE_OFFSET  = 3'd0,
        REG_MIRROR_OFFSET = 3'd1,
        REG_COEF_A1       = 3'd2,
        REG_COEF_A2       = 3'd3,
        REG_COEF_A3       = 3'd4,
        REG_COEF_B1       = 3'd5,
        REG_COEF_B2       = 3'd6,
        REG_COEF_B3       = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
    } cvec_t;

    // Pipeline control shared by all stages
    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctl_t;

    // Arctangent of 2^-i in Q2.30
    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/mirror_reflection_first_axis.sv
// ----------------------------------------------------------------------------
// mirror_reflection_first_axis: Householder reflection of the first mirror
// Maps two scanner commands to the five distinct entries of the mirror's
// 4x4 reflection matrix through a polynomial angle and a CORDIC cell chain.
// ----------------------------------------------------------------------------
//  channel   | signals                                  | direction
//  ----------+------------------------------------------+----------
//  request   | in_valid, in_ready, cmd_a, cmd_b         | in
//  result    | out_valid, out_ready, refl_*             | out
//  config    | cfg_we, cfg_idx, cfg_data                | in
//
//  One request per cycle while the output is not stalled; the pipeline has 7 angle
//  stages, 30 CORDIC cells and 5 matrix stages.
//  Reset clears the valid chain and all configuration registers to zero.
//  A result held at the output freezes the whole pipeline; in_ready drops
//  in that cycle and returns as soon as the result is taken.
// ----------------------------------------------------------------------------
module mirror_reflection_first_axis
    import mrfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] cmd_a,
    input  logic signed [15:0] cmd_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] refl_xx,
    output logic signed [31:0] refl_xy,
    output logic signed [31:0] refl_x_shift,
    output logic signed [31:0] refl_yy,
    output logic signed [31:0] refl_y_shift,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [31:0]        cfg_data
);

    logic signed [31:0] cfg_reg [NREG];
    logic               adv;
    pipe_ctl_t          ctl_in;
    cvec_t              chain     [STEPS+1];
    logic               chain_vld [STEPS+1];

    // Advance everything unless the output holds an untaken result
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign ctl_in   = '{en: adv, vld: in_valid};

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREG; i++)
                cfg_reg[i] <= '0;
        end
        else if (cfg_we)
            cfg_reg[cfg_idx] <= cfg_data;
    end

    mrfa_angle u_angle (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl_in),
        .cmd_a        (cmd_a),
        .cmd_b        (cmd_b),
        .angle_offset (cfg_reg[REG_ANGLE_OFFSET]),
        .coef_a1      (cfg_reg[REG_COEF_A1]),
        .coef_a2      (cfg_reg[REG_COEF_A2]),
        .coef_a3      (cfg_reg[REG_COEF_A3]),
        .coef_b1      (cfg_reg[REG_COEF_B1]),
        .coef_b2      (cfg_reg[REG_COEF_B2]),
        .coef_b3      (cfg_reg[REG_COEF_B3]),
        .vec          (chain[0]),
        .vec_vld      (chain_vld[0])
    );

    // Chain of CORDIC cells
    for (genvar g = 0; g < STEPS; g++)
    begin : g_cell
        pipe_ctl_t cell_ctl;
        assign cell_ctl = '{en: adv, vld: chain_vld[g]};

        mrfa_cordic_cell #(.STEP(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .vin      (chain[g]),
            .vout     (chain[g+1]),
            .vout_vld (chain_vld[g+1])
        );
    end

    pipe_ctl_t mat_ctl;
    assign mat_ctl = '{en: adv, vld: chain_vld[STEPS]};

    mrfa_matrix u_matrix (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (mat_ctl),
        .vec           (chain[STEPS]),
        .mirror_offset (cfg_reg[REG_MIRROR_OFFSET]),
        .res_vld       (out_valid),
        .refl_xx       (refl_xx),
        .refl_xy       (refl_xy),
        .refl_x_shift  (refl_x_shift),
        .refl_yy       (refl_yy),
        .refl_y_shift  (refl_y_shift)
    );

endmodule

// File: src/mrfa_angle.sv
// ----------------------------------------------------------------------------
// mrfa_angle: command polynomials, angle reduction and degree-to-radian step
// Seven pipeline stages from the two commands to the CORDIC start vector.
// ----------------------------------------------------------------------------
module mrfa_angle
    import mrfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pipe_ctl_t           ctl,
    input  logic signed [15:0]  cmd_a,
    input  logic signed [15:0]  cmd_b,
    input  logic signed [31:0]  angle_offset,
    input  logic signed [31:0]  coef_a1,
    input  logic signed [31:0]  coef_a2,
    input  logic signed [31:0]  coef_a3,
    input  logic signed [31:0]  coef_b1,
    input  logic signed [31:0]  coef_b2,
    input  logic signed [31:0]  coef_b3,
    output cvec_t               vec,
    output logic                vec_vld
);

    logic [6:0] vld_reg;

    // Stage 1: commands and their squares
    logic signed [15:0] a1_reg, b1_reg;
    logic signed [31:0] asq_reg, bsq_reg;
    // Stage 2: coefficient products
    logic signed [15:0] a2_reg, b2_reg;
    logic signed [47:0] p1a_reg, p1b_reg;
    logic signed [63:0] p2a_reg, p2b_reg, p3a_reg, p3b_reg;
    // Stage 3: cubic product and partial sum
    logic signed [47:0] q3a, q3b;
    logic signed [63:0] m3a_reg, m3b_reg, s12_reg, s12_next;
    // Stage 4: saturated angle
    logic signed [63:0] sum_next;
    logic signed [31:0] deg_reg, deg_next;
    // Stage 5: quotient by a full turn
    logic [16:0] n_next, n_reg;
    logic [32:0] qprod;
    logic [7:0]  q_reg;
    logic [15:0] frac_reg;
    // Stage 6: remainder and fold
    logic [16:0]        rem_raw, rem_fix;
    logic [24:0]        r_pos;
    logic signed [25:0] r_sgn, r_fold;
    logic               neg_next;
    logic signed [25:0] rf_reg;
    logic               neg6_reg;
    // Stage 7: radians
    logic signed [53:0] zprod;
    cvec_t              vec_reg;

    assign q3a = 48'(p3a_reg >>> 16);
    assign q3b = 48'(p3b_reg >>> 16);
    assign s12_next = 64'(angle_offset) + 64'(p1a_reg >>> 8) + (p2a_reg >>> 16)
                    + 64'(p1b_reg >>> 8) + (p2b_reg >>> 16);
    assign sum_next = s12_reg + (m3a_reg >>> 8) + (m3b_reg >>> 8);

    // Saturate the angle to Q16.16
    always_comb
    begin
        if (sum_next > 64'sd2147483647)
            deg_next = 32'sh7fffffff;
        else if (sum_next < -64'sd2147483648)
            deg_next = 32'sh80000000;
        else
            deg_next = 32'(sum_next);
    end

    // Integer degrees shifted by 92 turns so the dividend is never negative
    assign n_next = 17'({~deg_reg[31], deg_reg[30:16]}) + 17'd352;
    assign qprod  = n_next * 33'd46604;

    // Remainder into one turn, then into [-180, 180) and [-90, 90]
    always_comb
    begin
        rem_raw = n_reg - 17'(q_reg * 17'd360);
        rem_fix = (rem_raw >= 17'd360) ? rem_raw - 17'd360 : rem_raw;
        r_pos   = {rem_fix[8:0], frac_reg};
        r_sgn   = (r_pos >= DEG_HALF) ? $signed({1'b0, r_pos}) - DEG_FULL
                                      : $signed({1'b0, r_pos});
        neg_next = 1'b0;
        r_fold   = r_sgn;
        if (r_sgn > DEG_QUARTER)
        begin
            r_fold   = r_sgn - (DEG_FULL >>> 1);
            neg_next = 1'b1;
        end
        else if (r_sgn < -DEG_QUARTER)
        begin
            r_fold   = r_sgn + (DEG_FULL >>> 1);
            neg_next = 1'b1;
        end
    end

    assign zprod = rf_reg * $signed({1'b0, RAD_PER_DEG});

    // Advance the valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ctl.en)
            vld_reg <= {vld_reg[5:0], ctl.vld};
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            a1_reg   <= cmd_a;
            b1_reg   <= cmd_b;
            asq_reg  <= cmd_a * cmd_a;
            bsq_reg  <= cmd_b * cmd_b;

            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            p1a_reg  <= coef_a1 * a1_reg;
            p1b_reg  <= coef_b1 * b1_reg;
            p2a_reg  <= coef_a2 * asq_reg;
            p2b_reg  <= coef_b2 * bsq_reg;
            p3a_reg  <= coef_a3 * asq_reg;
            p3b_reg  <= coef_b3 * bsq_reg;

            m3a_reg  <= q3a * a2_reg;
            m3b_reg  <= q3b * b2_reg;
            s12_reg  <= s12_next;

            deg_reg  <= deg_next;

            n_reg    <= n_next;
            q_reg    <= qprod[31:24];
            frac_reg <= deg_reg[15:0];

            rf_reg   <= r_fold;
            neg6_reg <= neg_next;

            vec_reg.x   <= CORDIC_GAIN;
            vec_reg.y   <= '0;
            vec_reg.z   <= CW'(zprod >>> 18);
            vec_reg.neg <= neg6_reg;
        end
    end

    assign vec     = vec_reg;
    assign vec_vld = vld_reg[6];

endmodule

// File: src/mrfa_cordic_cell.sv
// ----------------------------------------------------------------------------
// mrfa_cordic_cell: one rotation-mode CORDIC iteration
// Rotates the vector toward zero residual angle and registers the result.
// ----------------------------------------------------------------------------
module mrfa_cordic_cell
    import mrfa_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl,
    input  cvec_t     vin,
    output cvec_t     vout,
    output logic      vout_vld
);

    localparam logic signed [CW-1:0] ANGLE = atan_q30(STEP);

    logic signed [CW-1:0] dx, dy;
    cvec_t                v_next, v_reg;
    logic                 vld_reg;

    assign dx = vin.y >>> STEP;
    assign dy = vin.x >>> STEP;

    // Rotate by the sign of the residual angle
    always_comb
    begin
        v_next.neg = vin.neg;
        if (!vin.z[CW-1])
        begin
            v_next.x = vin.x - dx;
            v_next.y = vin.y + dy;
            v_next.z = vin.z - ANGLE;
        end
        else
        begin
            v_next.x = vin.x + dx;
            v_next.y = vin.y - dy;
            v_next.z = vin.z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (ctl.en)
            vld_reg <= ctl.vld;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
            v_reg <= v_next;
    end

    assign vout     = v_reg;
    assign vout_vld = vld_reg;

endmodule

// File: src/mrfa_matrix.sv
// ----------------------------------------------------------------------------
// mrfa_matrix: reflection matrix entries from cos and sin
// Five stages: clamp and sign, products, rounding, offset scaling, saturation.
// ----------------------------------------------------------------------------
module mrfa_matrix
    import mrfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pipe_ctl_t          ctl,
    input  cvec_t              vec,
    input  logic signed [31:0] mirror_offset,
    output logic               res_vld,
    output logic signed [31:0] refl_xx,
    output logic signed [31:0] refl_xy,
    output logic signed [31:0] refl_x_shift,
    output logic signed [31:0] refl_yy,
    output logic signed [31:0] refl_y_shift
);

    localparam logic signed [CW-1:0] ONE = 34'sd1073741824;

    logic [4:0] vld_reg;

    logic signed [CW-1:0] c_cl, s_cl;
    logic signed [31:0]   c_reg, s_reg;
    logic signed [63:0]   cc_reg, cs_reg, ss_reg;
    logic signed [63:0]   t_xx, t_xy, t_yy;
    logic signed [31:0]   xx3_reg, xy3_reg, yy3_reg, csr_reg, ssr_reg;
    logic signed [31:0]   xx4_reg, xy4_reg, yy4_reg;
    logic signed [63:0]   px_reg, py_reg, rx, ry;
    logic signed [31:0]   xx_reg, xy_reg, yy_reg, xs_reg, ys_reg;

    // Clamp to [-1, 1]
    always_comb
    begin
        c_cl = vec.x;
        s_cl = vec.y;
        if (vec.x > ONE)  c_cl = ONE;
        if (vec.x < -ONE) c_cl = -ONE;
        if (vec.y > ONE)  s_cl = ONE;
        if (vec.y < -ONE) s_cl = -ONE;
    end

    assign t_xx = 64'sh1000000000000000 - (cc_reg <<< 1) + 64'sh80000000000;
    assign t_xy = 64'sh80000000000 - (cs_reg <<< 1);
    assign t_yy = 64'sh1000000000000000 - (ss_reg <<< 1) + 64'sh80000000000;

    // Round twice the scaled product by 30 bits
    assign rx = (px_reg + 64'sh10000000) >>> 29;
    assign ry = (py_reg + 64'sh10000000) >>> 29;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = 32'(v);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ctl.en)
            vld_reg <= {vld_reg[3:0], ctl.vld};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            c_reg   <= vec.neg ? -32'(c_cl) : 32'(c_cl);
            s_reg   <= vec.neg ? -32'(s_cl) : 32'(s_cl);

            cc_reg  <= c_reg * c_reg;
            cs_reg  <= c_reg * s_reg;
            ss_reg  <= s_reg * s_reg;

            xx3_reg <= 32'(t_xx >>> 44);
            xy3_reg <= 32'(t_xy >>> 44);
            yy3_reg <= 32'(t_yy >>> 44);
            csr_reg <= 32'((cs_reg + 64'sh20000000) >>> 30);
            ssr_reg <= 32'((ss_reg + 64'sh20000000) >>> 30);

            xx4_reg <= xx3_reg;
            xy4_reg <= xy3_reg;
            yy4_reg <= yy3_reg;
            px_reg  <= mirror_offset * csr_reg;
            py_reg  <= mirror_offset * ssr_reg;

            xx_reg  <= xx4_reg;
            xy_reg  <= xy4_reg;
            yy_reg  <= yy4_reg;
            xs_reg  <= sat32(rx);
            ys_reg  <= sat32(ry);
        end
    end

    assign res_vld      = vld_reg[4];
    assign refl_xx      = xx_reg;
    assign refl_xy      = xy_reg;
    assign refl_x_shift = xs_reg;
    assign refl_yy      = yy_reg;
    assign refl_y_shift = ys_reg;

endmodule

// File: src/mrfa_check.sv
// ----------------------------------------------------------------------------
// mrfa_check: port-level checks for the mirror reflection block
// Watches the handshakes and the range of the rotation entries.
// ----------------------------------------------------------------------------
module mrfa_check
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] refl_xx,
    input logic signed [31:0] refl_xy,
    input logic signed [31:0] refl_yy
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(refl_xx) && $stable(refl_xy))
        else $error("result changed while stalled");

    // A stalled output blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while output stalled");

    // An empty output never blocks requests
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("ready low with empty output");

    // Rotation entries stay within [-1, 1]
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> refl_xx <= 32'sd65536 && refl_xx >= -32'sd65536
                   && refl_yy <= 32'sd65536 && refl_yy >= -32'sd65536)
        else $error("rotation entry out of range");

endmodule

bind mirror_reflection_first_axis mrfa_check u_mrfa_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .refl_xx   (refl_xx),
    .refl_xy   (refl_xy),
    .refl_yy   (refl_yy)
);

// File: test/tb_mirror_reflection_first_axis.sv
// ----------------------------------------------------------------------------
// tb_mirror_reflection_first_axis: testbench for the first-axis mirror block
// Drives scanner command requests under random idling and a long output
// stall. A bit-exact predictor of the reflection entries feeds a scoreboard
// that compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_mirror_reflection_first_axis;
    import mrfa_pkg::*;

    // Fixed-point constants of the angle and CORDIC datapath
    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam longint FULL_TURN = 64'sd360 << 16;
    localparam longint HALF_TURN = 64'sd180 << 16;
    localparam longint QUARTER_TURN = 64'sd90 << 16;

    typedef struct packed {
        logic signed [31:0] xx;
        logic signed [31:0] xy;
        logic signed [31:0] x_shift;
        logic signed [31:0] yy;
        logic signed [31:0] y_shift;
    } refl_t;

    // Shift right with floor, and round with ties toward +infinity
    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_shr(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sat_w32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > ONE_Q30)
            return ONE_Q30;
        if (v < -ONE_Q30)
            return -ONE_Q30;
        return v;
    endfunction

    function automatic longint cubic_term(longint c, longint k1, longint k2, longint k3);
        longint c2;
        c2 = c * c;
        return floor_shr(k1 * c, 8) + floor_shr(k2 * c2, 16)
            + floor_shr(floor_shr(k3 * c2, 16) * c, 8);
    endfunction

    function automatic longint atan_step(int i);
        longint tbl[30];
        tbl = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                128, 64, 32, 16, 8, 4, 2};
        return tbl[i];
    endfunction

    // Scoreboard: holds predicted reflection entries in request order
    class refl_scoreboard;
        longint cfg[NREG];
        refl_t pending[$];
        int errors;

        function void write_reg(int idx, logic [31:0] val);
            cfg[idx] = longint'(signed'(val));
        endfunction

        function refl_t predict_reflection(logic signed [15:0] a, logic signed [15:0] b);
            refl_t res;
            longint deg, r, z, x, y, dx, dy, c, s, cs, ss, e;
            bit flip;
            flip = 0;
            e = cfg[REG_MIRROR_OFFSET];
            deg = cfg[REG_ANGLE_OFFSET]
                + cubic_term(a, cfg[REG_COEF_A1], cfg[REG_COEF_A2], cfg[REG_COEF_A3])
                + cubic_term(b, cfg[REG_COEF_B1], cfg[REG_COEF_B2], cfg[REG_COEF_B3]);
            deg = sat_w32(deg);
            r = deg % FULL_TURN;
            if (r < 0)
                r += FULL_TURN;
            if (r >= HALF_TURN)
                r -= FULL_TURN;
            if (r > QUARTER_TURN)
            begin
                r -= HALF_TURN;
                flip = 1;
            end
            else if (r < -QUARTER_TURN)
            begin
                r += HALF_TURN;
                flip = 1;
            end
            z = floor_shr(r * 64'sd74961321, 18);
            x = 64'sd652032874;
            y = 0;
            for (int i = 0; i < 30; i++)
            begin
                dx = floor_shr(y, i);
                dy = floor_shr(x, i);
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= atan_step(i);
                end
                else
                begin
                    x += dx; y -= dy; z += atan_step(i);
                end
            end
            c = clamp_unit(x);
            s = clamp_unit(y);
            if (flip)
            begin
                c = -c; s = -s;
            end
            cs = c * s;
            ss = s * s;
            res.xx = 32'(round_shr((64'sd1 << 60) - 2 * c * c, 44));
            res.xy = 32'(round_shr(-2 * cs, 44));
            res.x_shift = 32'(sat_w32(round_shr(2 * e * round_shr(cs, 30), 30)));
            res.yy = 32'(round_shr((64'sd1 << 60) - 2 * ss, 44));
            res.y_shift = 32'(sat_w32(round_shr(2 * e * round_shr(ss, 30), 30)));
            return res;
        endfunction

        function void note_request(logic signed [15:0] a, logic signed [15:0] b);
            pending.push_back(predict_reflection(a, b));
        endfunction

        function void check_result(refl_t got);
            refl_t exp_r;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result xx=%0d", got.xx);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                        exp_r.xx, exp_r.xy, exp_r.x_shift, exp_r.yy, exp_r.y_shift,
                        got.xx, got.xy, got.x_shift, got.yy, got.y_shift);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [15:0] cmd_a = '0;
    logic signed [15:0] cmd_b = '0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [31:0] refl_xx, refl_xy, refl_x_shift, refl_yy, refl_y_shift;
    logic cfg_we = 0;
    logic [2:0] cfg_idx = '0;
    logic [31:0] cfg_data = '0;

    refl_scoreboard sb = new();
    bit calm = 0;          // no idling in the final part
    int hold_off = 0;      // long receiver stall, in cycles

    mirror_reflection_first_axis uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sample accepted requests and results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_request(cmd_a, cmd_b);
        if (rst_n && out_valid && out_ready)
            sb.check_result('{refl_xx, refl_xy, refl_x_shift, refl_yy, refl_y_shift});
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_ready <= 0;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 9);
                out_ready <= 0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                out_ready <= 1;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // Offer one request, with an optional idle burst before it; valid stays
    // high on return so that requests can follow back to back
    task automatic send_cmd(logic [15:0] a, logic [15:0] b);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1;
        cmd_a <= a;
        cmd_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coef(int mode);
        case (mode)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
        endcase
    endfunction

    task automatic random_setting(int mode);
        for (int i = 0; i < NREG; i++)
            write_reg(reg_idx_t'(i), rand_coef((mode == 2) ? $urandom_range(0, 3) : mode));
    endtask

    initial
    begin
        logic [15:0] edge_vals[5];
        edge_vals = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Directed: reset config, then extremes and 180-degree angles with linear coefficients only
        for (int i = 0; i < 5; i++)
            send_cmd(edge_vals[i], edge_vals[4 - i]);
        drain();
        write_reg(REG_COEF_A1, 32'h00010000);
        write_reg(REG_COEF_B1, 32'h00020000);
        write_reg(REG_MIRROR_OFFSET, 32'h7fffffff);
        write_reg(REG_ANGLE_OFFSET, 32'h005a0000);   // 90 degrees
        for (int i = 0; i < 5; i++)
            send_cmd(edge_vals[i], edge_vals[i]);
        send_cmd(16'sd0, 16'(45 << 8));              // 180 degrees total
        send_cmd(16'(90 << 8), 16'sd0);              // 180 degrees
        drain();
        // Saturated angle and saturated translation terms
        random_setting(0);
        for (int i = 0; i < 5; i++)
            send_cmd(edge_vals[i], edge_vals[(i + 2) % 5]);
        drain();
        random_setting(1);
        for (int i = 0; i < 5; i++)
            send_cmd(edge_vals[i], edge_vals[(i + 1) % 5]);
        drain();

        // Random phases; the second one carries the long output stall
        for (int ph = 0; ph < 5; ph++)
        begin
            random_setting((ph == 0) ? 3 : 2);
            if (ph == 1)
                hold_off = 200;
            if (ph == 4)
                calm = 1;
            for (int n = 0; n < 100; n++)
                send_cmd(16'($urandom), 16'($urandom));
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
